// ----- rtl/assert_macros.svh -----
// Assertion macros used by the framer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: ante implies cons");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: ante implies cons next cycle");

`endif

// ----- rtl/dsfe_pkg.sv -----
// Shared constants and types of the DLE-stuffed frame encoder.
package dsfe_pkg;

  localparam logic [7:0] DLE_BYTE = 8'h10;
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  // One-hot slot codes, in transmit order.
  localparam int unsigned NUM_SLOTS = 7;
  localparam logic [NUM_SLOTS-1:0] SLOT_SOF_DLE = 7'b000_0001;
  localparam logic [NUM_SLOTS-1:0] SLOT_SOF_STX = 7'b000_0010;
  localparam logic [NUM_SLOTS-1:0] SLOT_ESC     = 7'b000_0100;
  localparam logic [NUM_SLOTS-1:0] SLOT_DATA    = 7'b000_1000;
  localparam logic [NUM_SLOTS-1:0] SLOT_EOF_DLE = 7'b001_0000;
  localparam logic [NUM_SLOTS-1:0] SLOT_EOF_ETX = 7'b010_0000;
  localparam logic [NUM_SLOTS-1:0] SLOT_SUM     = 7'b100_0000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       frame_end;
  } dsfe_beat_t;

  typedef struct packed {
    logic busy;    // slot register holds bytes still to send
    logic emit;    // a byte moves to the output register this cycle
    logic finish;  // that byte is the last one of its transaction
  } dsfe_status_t;

endpackage

// ----- rtl/dsfe_slot.sv -----
// Input slot register: holds one transaction and sequences its output bytes.
module dsfe_slot (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  frame_last_i,
  output logic                  in_stall_o,
  input  logic                  advance_i,
  output dsfe_pkg::dsfe_beat_t  beat_o,
  output dsfe_pkg::dsfe_status_t st_o
);

  logic [dsfe_pkg::NUM_SLOTS-1:0] mask_q, mask_d, sel, rest, new_mask;
  logic [7:0] data_q, data_d, sum_q, sum_d, byte_sel;
  logic       inside_q, inside_d;
  logic       busy, emit, finish, accept, idle_next;

  assign busy   = (mask_q != '0);
  assign sel    = mask_q & (~mask_q + {{(dsfe_pkg::NUM_SLOTS-1){1'b0}}, 1'b1});
  assign rest   = mask_q & ~sel;
  assign emit   = busy && advance_i;
  assign finish = emit && (rest == '0);

  assign idle_next  = !busy || finish;
  assign in_stall_o = !idle_next;
  assign accept     = in_valid_i && idle_next;

  assign new_mask = {frame_last_i, frame_last_i, frame_last_i, 1'b1,
                     (data_byte_i == dsfe_pkg::DLE_BYTE), !inside_q, !inside_q};

  always_comb begin
    case (sel)
      dsfe_pkg::SLOT_SOF_DLE: byte_sel = dsfe_pkg::DLE_BYTE;
      dsfe_pkg::SLOT_SOF_STX: byte_sel = dsfe_pkg::STX_BYTE;
      dsfe_pkg::SLOT_ESC:     byte_sel = dsfe_pkg::DLE_BYTE;
      dsfe_pkg::SLOT_EOF_DLE: byte_sel = dsfe_pkg::DLE_BYTE;
      dsfe_pkg::SLOT_EOF_ETX: byte_sel = dsfe_pkg::ETX_BYTE;
      dsfe_pkg::SLOT_SUM:     byte_sel = sum_q;
      default:                byte_sel = data_q;
    endcase
  end

  always_comb begin
    mask_d   = mask_q;
    data_d   = data_q;
    inside_d = inside_q;
    sum_d    = sum_q;
    if (emit) begin
      mask_d = rest;
      sum_d  = (sel == dsfe_pkg::SLOT_SUM) ? 8'h00 : sum_q + byte_sel;
    end
    if (accept) begin
      mask_d   = new_mask;
      data_d   = data_byte_i;
      inside_d = !frame_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      inside_q <= 1'b0;
      sum_q    <= 8'h00;
    end else begin
      mask_q   <= mask_d;
      inside_q <= inside_d;
      sum_q    <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign beat_o.out_byte  = byte_sel;
  assign beat_o.run_end   = (rest == '0);
  assign beat_o.frame_end = (sel == dsfe_pkg::SLOT_SUM);

  assign st_o.busy   = busy;
  assign st_o.emit   = emit;
  assign st_o.finish = finish;

endmodule

// ----- rtl/dsfe_out.sv -----
// Output register: holds one byte until the receiver takes it.
module dsfe_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 emit_i,
  input  dsfe_pkg::dsfe_beat_t beat_i,
  output logic                 advance_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 run_end_o,
  output logic                 frame_end_o
);

  logic                 valid_q, valid_d;
  dsfe_pkg::dsfe_beat_t beat_q, beat_d;

  assign advance_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    beat_d  = beat_q;
    if (emit_i) begin
      valid_d = 1'b1;
      beat_d  = beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = beat_q.out_byte;
  assign run_end_o   = beat_q.run_end;
  assign frame_end_o = beat_q.frame_end;

endmodule

// ----- rtl/dle_stuffed_frame_encoder.sv -----
// Top level of the DLE/STX/ETX byte-stuffing frame encoder.
//
// Input channel (in_valid_i / in_stall_o): one payload byte per transaction,
// with frame_last_i set on the final byte of a frame. Output channel
// (out_valid_o / out_stall_i): one link byte per transaction. run_end_o marks
// the last byte caused by an input transaction, frame_end_o the checksum.
// Each input transaction expands to 1 to 7 output bytes: start pair 10 02
// when no frame is open, an escape 10 before a data byte of 10, the data
// byte, and for the last byte the end pair 10 03 plus the mod-256 sum of all
// bytes sent in the frame.
// Each link byte is held in the slot register, then in the output register.
// Throughput: one output byte per clock while the receiver does not stall,
// set by the single output byte lane. The next input is accepted in the same
// clock the previous transaction's last byte moves to the output register.
// Reset clears the slot, the open-frame flag, the running sum and the output
// valid. While the receiver stalls, hold the output register and the slot;
// input stall then rises once the slot has bytes left to send.
`include "assert_macros.svh"

module dle_stuffed_frame_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       frame_end_o
);

  dsfe_pkg::dsfe_beat_t   beat;
  dsfe_pkg::dsfe_status_t st;
  logic                   advance;

  // Slot register plus byte selection and checksum accumulation.
  dsfe_slot u_slot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .frame_last_i(frame_last_i),
    .in_stall_o  (in_stall_o),
    .advance_i   (advance),
    .beat_o      (beat),
    .st_o        (st)
  );

  // Output register, frees the slot whenever it is empty or being drained.
  dsfe_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (st.emit),
    .beat_i      (beat),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_end_o   (run_end_o),
    .frame_end_o (frame_end_o)
  );

  // Checksum byte always closes its transaction.
  `ASSERT_IMPLY(a_sum_ends_run, clk_i, rst_ni, out_valid_o && frame_end_o, run_end_o)
  // An accepted transaction leaves bytes in the slot.
  `ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, in_valid_i && !in_stall_o, st.busy)
  // A busy slot only takes new input while sending its final byte.
  `ASSERT_IMPLY(a_accept_when_done, clk_i, rst_ni, st.busy && in_valid_i && !in_stall_o, st.finish)

endmodule

// ----- bench/tb_dle_stuffed_frame_encoder.sv -----
// Self-checking testbench for the DLE/STX/ETX byte-stuffing frame encoder.
module tb_dle_stuffed_frame_encoder;

  // Run length in payload bytes; hold-off, watchdog and tail limits in clock cycles.
  localparam int unsigned RANDOM_BYTES  = 306;
  localparam int unsigned LONG_HOLD     = 250;  // receiver hold-off, long enough to back up
  localparam int unsigned HOLD_AFTER    = 300;  // link bytes seen before that hold-off
  localparam int unsigned DRAIN_AT      = 200;  // random payload byte that waits for a drain
  localparam int unsigned WATCHDOG      = 2000; // cycles with no transaction on either side
  localparam int unsigned TAIL_CYCLES   = 16;   // settle time after the last link byte

  // One payload transaction plus the idle time the sender keeps after it.
  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned gap_after;
    bit          wait_drain;  // hold this byte back until every link byte has arrived
  } payload_item_t;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte   = 8'h00;
  logic       frame_last  = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] out_byte;
  logic       run_end;
  logic       frame_end;

  payload_item_t        payload_q[$];
  dsfe_pkg::dsfe_beat_t link_bytes_q[$];   // link bytes predicted but not yet seen on the output

  // Predictor state: mirrors the open-frame flag and the running checksum.
  logic        frame_open = 1'b0;
  logic [7:0]  frame_sum  = 8'h00;

  int unsigned payload_total   = 0;
  int unsigned payload_taken   = 0;
  int unsigned link_bytes_seen = 0;
  int unsigned frames_closed   = 0;
  int unsigned escapes_sent    = 0;
  int unsigned max_run         = 0;
  int unsigned idle_cycles     = 0;
  int unsigned cycle_count     = 0;
  int unsigned errors          = 0;
  int unsigned gap_left        = 0;
  int unsigned stall_left      = 0;
  int unsigned hold_left       = 0;
  bit          hold_done       = 1'b0;
  bit          timed_out       = 1'b0;

  dle_stuffed_frame_encoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_byte_i  (data_byte),
    .frame_last_i (frame_last),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte),
    .run_end_o    (run_end),
    .frame_end_o  (frame_end)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Queue one link byte; every byte except the checksum itself feeds the sum.
  function automatic void push_link_byte(logic [7:0] value, logic is_sum);
    dsfe_pkg::dsfe_beat_t beat;
    beat.out_byte  = value;
    beat.run_end   = 1'b0;
    beat.frame_end = is_sum;
    link_bytes_q.push_back(beat);
    if (!is_sum) frame_sum = frame_sum + value;
  endfunction

  // Expand one accepted payload byte into the link bytes it must produce.
  function automatic void frame_encode(logic [7:0] data, logic last);
    int unsigned depth_before;
    depth_before = link_bytes_q.size();
    // Open a frame: start pair, and restart the checksum.
    if (!frame_open) begin
      frame_sum = 8'h00;
      push_link_byte(dsfe_pkg::DLE_BYTE, 1'b0);
      push_link_byte(dsfe_pkg::STX_BYTE, 1'b0);
      frame_open = 1'b1;
    end
    // Stuff a payload byte that looks like the escape character.
    if (data == dsfe_pkg::DLE_BYTE) begin
      push_link_byte(dsfe_pkg::DLE_BYTE, 1'b0);
      escapes_sent++;
    end
    push_link_byte(data, 1'b0);
    // Close the frame: end pair, then the checksum of everything sent so far.
    if (last) begin
      push_link_byte(dsfe_pkg::DLE_BYTE, 1'b0);
      push_link_byte(dsfe_pkg::ETX_BYTE, 1'b0);
      push_link_byte(frame_sum, 1'b1);
      frame_open = 1'b0;
      frame_sum  = 8'h00;
      frames_closed++;
    end
    link_bytes_q[link_bytes_q.size()-1].run_end = 1'b1;
    if (link_bytes_q.size() - depth_before > max_run) max_run = link_bytes_q.size() - depth_before;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic void add_payload(logic [7:0] data, logic last, int unsigned gap,
                                      bit wait_drain);
    payload_item_t item;
    item.data       = data;
    item.last       = last;
    item.gap_after  = gap;
    item.wait_drain = wait_drain;
    payload_q.push_back(item);
  endfunction

  // Favor escape and delimiter values and the extremes 00 and FF.
  function automatic logic [7:0] pick_payload_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return dsfe_pkg::DLE_BYTE;
    if (r < 26) return dsfe_pkg::STX_BYTE;
    if (r < 32) return dsfe_pkg::ETX_BYTE;
    if (r < 36) return 8'h00;
    if (r < 40) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present payload bytes from the queue, hold each until accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    payload_item_t item;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        frame_encode(data_byte, frame_last);
        payload_taken++;
      end
      // Advance only when nothing is on offer or the offer was just taken.
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (payload_q.size() > 0 &&
                     (!payload_q[0].wait_drain || link_bytes_q.size() == 0)) begin
          item = payload_q.pop_front();
          in_valid   <= 1'b1;
          data_byte  <= item.data;
          frame_last <= item.last;
          gap_left   = item.gap_after;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each link byte against the oldest prediction, drive stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    dsfe_pkg::dsfe_beat_t want;
    int unsigned r;
    if (rst_ni) begin
      cycle_count++;
      if (out_valid && !out_stall) begin
        link_bytes_seen++;
        if (link_bytes_q.size() == 0) begin
          $error("unexpected link byte %02h (run_end %0b, frame_end %0b)",
                 out_byte, run_end, frame_end);
          errors++;
        end else begin
          want = link_bytes_q.pop_front();
          if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte);
            errors++;
          end
          if (run_end !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, run_end);
            errors++;
          end
          if (frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
            errors++;
          end
        end
      end

      // Receiver back-pressure. One long hold-off lets the encoder fill up and
      // stall its input; otherwise alternate calm stretches with random stalls.
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && link_bytes_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (cycle_count[8:7] == 2'd0) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_stall <= 1'b0;
        end else if (r < 93) begin
          out_stall <= 1'b1;
          stall_left = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          stall_left = $urandom_range(8, 30);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel completes a transaction.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned len;
    int unsigned k;
    bit          burst;

    // Directed part.
    // One-byte frames: start pair and end pair around a single byte, the
    // second one also stuffed, which gives the longest expansion.
    add_payload(8'h00, 1'b1, 0, 1'b0);
    add_payload(dsfe_pkg::DLE_BYTE, 1'b1, 0, 1'b0);
    add_payload(8'hFF, 1'b1, 2, 1'b0);
    // A frame full of escape and delimiter values, back to back escapes.
    add_payload(8'hFF, 1'b0, 0, 1'b0);
    add_payload(dsfe_pkg::DLE_BYTE, 1'b0, 0, 1'b0);
    add_payload(dsfe_pkg::DLE_BYTE, 1'b0, 0, 1'b0);
    add_payload(dsfe_pkg::STX_BYTE, 1'b0, 0, 1'b0);
    add_payload(dsfe_pkg::ETX_BYTE, 1'b0, 1, 1'b0);
    add_payload(dsfe_pkg::DLE_BYTE, 1'b1, 0, 1'b0);
    // Walk a single set bit through the data byte, then 7F, 80 and FE.
    for (k = 0; k < 8; k++) add_payload(8'(1 << k), 1'b0, 0, 1'b0);
    add_payload(8'h7F, 1'b0, 0, 1'b0);
    add_payload(8'h80, 1'b0, 0, 1'b0);
    add_payload(8'hFE, 1'b1, 0, 1'b0);
    // A frame of 0xFF bytes drives the checksum through several wraps.
    for (k = 0; k < 4; k++) add_payload(8'hFF, k == 3, 0, 1'b0);

    // Random part: well-formed frames of random content, most of them short.
    // The first random byte waits until everything before it has drained.
    while (payload_q.size() < 24 + RANDOM_BYTES) begin
      len   = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 20);
      burst = ($urandom_range(0, 99) < 25);
      for (k = 0; k < len; k++) begin
        add_payload(pick_payload_byte(), k == len - 1, burst ? 0 : pick_gap(),
                    payload_q.size() == 24 || payload_q.size() == 24 + DRAIN_AT);
      end
    end
    payload_total = payload_q.size();

    // Hold reset, then release it on a clock edge.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(payload_taken == payload_total && link_bytes_q.size() == 0) &&
           idle_cycles < WATCHDOG) @(posedge clk_i);

    if (idle_cycles >= WATCHDOG) begin
      timed_out = 1'b1;
      $error("watchdog: no transaction for %0d cycles, %0d of %0d payload bytes taken",
             WATCHDOG, payload_taken, payload_total);
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
    end

    if (link_bytes_q.size() != 0) begin
      $error("%0d predicted link bytes never arrived", link_bytes_q.size());
      errors++;
    end

    $display("Framed %0d payload bytes into %0d link bytes, %0d frames closed.",
             payload_taken, link_bytes_seen, frames_closed);
    $display("Stuffed %0d escape bytes; longest expansion of one byte was %0d link bytes.",
             escapes_sent, max_run);
    if (errors == 0 && !timed_out) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/dsfe_pkg.sv
rtl/dsfe_slot.sv
rtl/dsfe_out.sv
rtl/dle_stuffed_frame_encoder.sv
bench/tb_dle_stuffed_frame_encoder.sv
